@@ hw/rtl/sdspi_pkg.sv @@
// ----------------------------------------------------------------------------
// SD SPI sequencer package
// Phase codes, item kinds and field widths shared by the sequencer files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdspi_pkg;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_XCHG  = 2'd2;
    localparam logic [1:0] CMD_TICK  = 2'd3;

    localparam logic [4:0] PH_IDLE    = 5'd1;
    localparam logic [4:0] PH_INIT_STD = 5'd2;
    localparam logic [4:0] PH_INIT_HC = 5'd3;
    localparam logic [4:0] PH_READ_OK = 5'd4;
    localparam logic [4:0] PH_INIT_TO = 5'd5;
    localparam logic [4:0] PH_REJECT  = 5'd6;
    localparam logic [4:0] PH_RD_FAIL = 5'd7;
    localparam logic [4:0] PH_TOK_TO  = 5'd8;
    localparam logic [4:0] PH_PWRUP   = 5'd9;
    localparam logic [4:0] PH_DUMMY   = 5'd10;
    localparam logic [4:0] PH_PRE     = 5'd11;
    localparam logic [4:0] PH_WAIT    = 5'd12;
    localparam logic [4:0] PH_SEND    = 5'd13;
    localparam logic [4:0] PH_RESP    = 5'd14;
    localparam logic [4:0] PH_TAIL    = 5'd15;
    localparam logic [4:0] PH_TOKEN   = 5'd16;
    localparam logic [4:0] PH_DATA    = 5'd17;
    localparam logic [4:0] PH_CRC     = 5'd18;

    localparam logic [3:0] STEP_READ = 4'd9;

    localparam logic [1:0] REG_PWRUP = 2'd0;
    localparam logic [1:0] REG_CMDTO = 2'd1;
    localparam logic [1:0] REG_INITTO = 2'd2;
    localparam logic [1:0] REG_DATATO = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] block_addr;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       cs_active;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       data_last;
        logic [3:0] status;
        logic [1:0] card_kind;
    } result_t;

endpackage

@@ hw/rtl/sdspi_core.sv @@
// ----------------------------------------------------------------------------
// SD SPI sequencer core
// Holds sequencer state; one item, one result per cycle with step_en high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdspi_core #(
    parameter int BLOCK_BYTES = 512,
    parameter int DUMMY_BYTES = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  sdspi_pkg::item_t   item,
    input  logic [15:0]        powerup_wait_ticks,
    input  logic [15:0]        cmd_timeout_ticks,
    input  logic [15:0]        init_timeout_ticks,
    input  logic [15:0]        data_timeout_ticks,
    output sdspi_pkg::result_t result
);

    localparam logic [9:0] BlockLast = 10'(BLOCK_BYTES - 1);
    localparam logic [9:0] DummyCnt  = 10'(DUMMY_BYTES);

    logic [4:0]  phase_reg, phase_next;
    logic [3:0]  step_reg, step_next;
    logic [9:0]  cnt_reg, cnt_next;
    logic [31:0] word_reg, word_next;
    logic [7:0]  code_reg, code_next;
    logic [15:0] ctim_reg, ctim_next;
    logic [15:0] otim_reg, otim_next;
    logic [1:0]  kind_reg, kind_next;
    logic [31:0] addr_reg, addr_next;

    logic        dv, dl;
    logic [7:0]  db;
    logic [3:0]  sidx;
    logic [15:0] ctim_inc, otim_inc;
    logic        fin_req, fin_ok;
    logic [7:0]  fin_r1;
    logic [31:0] fin_word;

    function automatic logic [3:0] sidx_of(input logic [3:0] s);
        return (s <= 4'd9) ? s : 4'd0;
    endfunction

    function automatic logic [7:0] send_byte(input logic [3:0] s, input logic [9:0] i,
                                             input logic [31:0] ra);
        logic [31:0] arg;
        logic [7:0]  cm;
        logic [7:0]  crc;
        arg = 32'd0;
        cm  = 8'd0;
        crc = 8'd0;
        unique case (s)
            4'd2: begin arg = 32'h1AA; cm = 8'd8; crc = 8'h87; end
            4'd1: begin crc = 8'h95; end
            4'd3, 4'd5: begin cm = 8'd55; crc = 8'hFF; end
            4'd4: begin cm = 8'd41; crc = 8'hFF; end
            4'd6: begin cm = 8'd41; crc = 8'hFF; arg = 32'h4000_0000; end
            4'd7: cm = 8'd58;
            4'd8: begin cm = 8'd16; arg = 32'(BLOCK_BYTES); end
            4'd9: begin cm = 8'd17; arg = ra; end
            default: ;
        endcase
        if (i == 10'd0) return 8'h40 | cm;
        unique case (i)
            10'd1: return arg[31:24];
            10'd2: return arg[23:16];
            10'd3: return arg[15:8];
            10'd4: return arg[7:0];
            default: return crc;
        endcase
    endfunction

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        word_next  = word_reg;
        code_next  = code_reg;
        ctim_next  = ctim_reg;
        otim_next  = otim_reg;
        kind_next  = kind_reg;
        addr_next  = addr_reg;
        dv = 1'b0;
        db = 8'd0;
        dl = 1'b0;
        fin_req = 1'b0;
        fin_ok  = 1'b0;
        fin_r1  = code_reg;
        fin_word = word_reg;
        sidx = sidx_of(step_reg);
        ctim_inc = (ctim_reg != 16'hFFFF) ? ctim_reg + 16'd1 : ctim_reg;
        otim_inc = (otim_reg != 16'hFFFF) ? otim_reg + 16'd1 : otim_reg;

        unique case (item.cmd)
            sdspi_pkg::CMD_INIT: begin
                if (phase_reg <= sdspi_pkg::PH_TOK_TO) begin
                    kind_next = 2'd0;
                    step_next = 4'd0;
                    cnt_next  = 10'd0;
                    ctim_next = 16'd0;
                    otim_next = 16'd0;
                    phase_next = (powerup_wait_ticks == 16'd0) ? sdspi_pkg::PH_DUMMY
                                                               : sdspi_pkg::PH_PWRUP;
                end
            end
            sdspi_pkg::CMD_READ: begin
                if (phase_reg <= sdspi_pkg::PH_TOK_TO) begin
                    addr_next  = item.block_addr;
                    step_next  = sdspi_pkg::STEP_READ;
                    phase_next = sdspi_pkg::PH_PRE;
                    cnt_next   = 10'd0;
                    ctim_next  = 16'd0;
                    word_next  = 32'd0;
                end
            end
            sdspi_pkg::CMD_XCHG: begin
                unique case (phase_reg)
                    sdspi_pkg::PH_DUMMY: begin
                        cnt_next = cnt_reg + 10'd1;
                        if (cnt_next >= DummyCnt) begin
                            step_next  = 4'd1;
                            phase_next = sdspi_pkg::PH_PRE;
                            cnt_next   = 10'd0;
                            ctim_next  = 16'd0;
                            word_next  = 32'd0;
                        end
                    end
                    sdspi_pkg::PH_PRE, sdspi_pkg::PH_WAIT: begin
                        if (item.rx_byte == 8'hFF) begin
                            phase_next = sdspi_pkg::PH_SEND;
                            cnt_next   = 10'd0;
                        end else begin
                            phase_next = sdspi_pkg::PH_WAIT;
                        end
                    end
                    sdspi_pkg::PH_SEND: begin
                        cnt_next = cnt_reg + 10'd1;
                        if (cnt_next >= 10'd6) phase_next = sdspi_pkg::PH_RESP;
                    end
                    sdspi_pkg::PH_RESP: begin
                        if (!item.rx_byte[7]) begin
                            code_next = item.rx_byte;
                            if (sidx == 4'd2 || sidx == 4'd7) begin
                                phase_next = sdspi_pkg::PH_TAIL;
                                cnt_next   = 10'd0;
                            end else begin
                                fin_req = 1'b1;
                                fin_ok  = 1'b1;
                                fin_r1  = item.rx_byte;
                            end
                        end
                    end
                    sdspi_pkg::PH_TAIL: begin
                        word_next = {word_reg[23:0], item.rx_byte};
                        cnt_next  = cnt_reg + 10'd1;
                        if (cnt_next >= 10'd4) begin
                            fin_req  = 1'b1;
                            fin_ok   = 1'b1;
                            fin_word = word_next;
                        end
                    end
                    sdspi_pkg::PH_TOKEN: begin
                        if (item.rx_byte == 8'hFE) begin
                            phase_next = sdspi_pkg::PH_DATA;
                            cnt_next   = 10'd0;
                        end
                    end
                    sdspi_pkg::PH_DATA: begin
                        dv = 1'b1;
                        db = item.rx_byte;
                        if (cnt_reg >= BlockLast) begin
                            dl = 1'b1;
                            phase_next = sdspi_pkg::PH_CRC;
                            cnt_next   = 10'd0;
                        end else begin
                            cnt_next = cnt_reg + 10'd1;
                        end
                    end
                    sdspi_pkg::PH_CRC: begin
                        cnt_next = cnt_reg + 10'd1;
                        if (cnt_next >= 10'd2) phase_next = sdspi_pkg::PH_READ_OK;
                    end
                    default: ;
                endcase
            end
            sdspi_pkg::CMD_TICK: begin
                if (phase_reg == sdspi_pkg::PH_PWRUP) begin
                    ctim_next = ctim_inc;
                    if (ctim_inc >= powerup_wait_ticks) begin
                        phase_next = sdspi_pkg::PH_DUMMY;
                        cnt_next   = 10'd0;
                        otim_next  = 16'd0;
                    end
                end else if (phase_reg > sdspi_pkg::PH_TOK_TO) begin
                    if (sidx != sdspi_pkg::STEP_READ && otim_inc >= init_timeout_ticks) begin
                        otim_next  = otim_inc;
                        phase_next = sdspi_pkg::PH_INIT_TO;
                        kind_next  = 2'd0;
                    end else begin
                        if (sidx != sdspi_pkg::STEP_READ) otim_next = otim_inc;
                        if (phase_reg >= sdspi_pkg::PH_PRE && phase_reg <= sdspi_pkg::PH_TAIL)
                        begin
                            ctim_next = ctim_inc;
                            if ((phase_reg == sdspi_pkg::PH_PRE || phase_reg == sdspi_pkg::PH_WAIT
                                 || phase_reg == sdspi_pkg::PH_RESP)
                                && ctim_inc >= cmd_timeout_ticks) begin
                                fin_req = 1'b1;
                            end
                        end else if (phase_reg == sdspi_pkg::PH_TOKEN) begin
                            otim_next = otim_inc;
                            if (otim_inc >= data_timeout_ticks)
                                phase_next = sdspi_pkg::PH_TOK_TO;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (fin_req) begin
            if (sidx == sdspi_pkg::STEP_READ) begin
                if (fin_ok && fin_r1 == 8'd0) begin
                    phase_next = sdspi_pkg::PH_TOKEN;
                    otim_next  = 16'd0;
                end else begin
                    phase_next = sdspi_pkg::PH_RD_FAIL;
                end
            end else begin
                phase_next = sdspi_pkg::PH_PRE;
                cnt_next   = 10'd0;
                ctim_next  = 16'd0;
                word_next  = 32'd0;
                if (fin_ok) begin
                    unique case (sidx)
                        4'd1: if (fin_r1 == 8'd1) step_next = 4'd2;
                        4'd2: begin
                            if (fin_r1 == 8'd1) begin
                                if (fin_word == 32'h1AA) begin
                                    step_next = 4'd5;
                                    kind_next = 2'd2;
                                end
                            end else begin
                                step_next = 4'd3;
                                kind_next = 2'd1;
                            end
                        end
                        4'd3, 4'd5: begin
                            if (fin_r1 == 8'd1) begin
                                step_next = step_reg + 4'd1;
                            end else begin
                                phase_next = sdspi_pkg::PH_REJECT;
                                kind_next  = 2'd0;
                            end
                        end
                        4'd4: step_next = (fin_r1 == 8'd0) ? 4'd8 : 4'd3;
                        4'd6: step_next = (fin_r1 == 8'd0) ? 4'd7 : 4'd5;
                        4'd7: begin
                            if (fin_r1 == 8'd0) begin
                                if (fin_word[30]) begin
                                    kind_next  = 2'd3;
                                    phase_next = sdspi_pkg::PH_INIT_HC;
                                end else begin
                                    step_next = 4'd8;
                                end
                            end
                        end
                        4'd8: if (fin_r1 == 8'd0) phase_next = sdspi_pkg::PH_INIT_STD;
                        default: step_next = 4'd1;
                    endcase
                    if (phase_next != sdspi_pkg::PH_PRE) begin
                        cnt_next  = cnt_reg;
                        ctim_next = ctim_reg;
                        word_next = fin_word;
                        if (item.cmd == sdspi_pkg::CMD_XCHG) cnt_next = cnt_reg + 10'd1;
                        if (phase_reg != sdspi_pkg::PH_TAIL) begin
                            cnt_next  = cnt_reg;
                            word_next = word_reg;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sdspi_pkg::PH_IDLE;
            step_reg  <= 4'd0;
            cnt_reg   <= 10'd0;
            word_reg  <= 32'd0;
            code_reg  <= 8'd0;
            ctim_reg  <= 16'd0;
            otim_reg  <= 16'd0;
            kind_reg  <= 2'd0;
            addr_reg  <= 32'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            word_reg  <= word_next;
            code_reg  <= code_next;
            ctim_reg  <= ctim_next;
            otim_reg  <= otim_next;
            kind_reg  <= kind_next;
            addr_reg  <= addr_next;
        end
    end

    always_comb begin
        result.tx_valid   = phase_next >= sdspi_pkg::PH_DUMMY;
        result.tx_byte    = (phase_next == sdspi_pkg::PH_SEND)
                            ? send_byte(sidx_of(step_next), cnt_next, addr_next) : 8'hFF;
        result.cs_active  = phase_next >= sdspi_pkg::PH_WAIT;
        result.data_valid = dv;
        result.data_byte  = db;
        result.data_last  = dl;
        result.status     = (phase_next <= sdspi_pkg::PH_TOK_TO) ? phase_next[3:0] : 4'd0;
        result.card_kind  = kind_next;
    end

endmodule

@@ hw/rtl/sd_spi_init_and_block_read.sv @@
// ----------------------------------------------------------------------------
// SD card SPI initialization and block read sequencer
// Stream wrapper with an input register, the sequencer core and a result
// register.
// ----------------------------------------------------------------------------
// Each transfer on the s_ side is one item (start init, start read, exchanged
// byte or millisecond tick) and yields exactly one transfer on the m_ side.
// Items are registered, stepped through the core and the result is registered,
// so one item per cycle is sustained while m_tready is high; the input register
// is ready whenever its content moves on or it is empty. Configuration must be
// written via cfg_ channel while the sequencer is idle; not enforced by the block.
`timescale 1ns / 1ps

module sd_spi_init_and_block_read #(
    parameter int BLOCK_BYTES = 512,
    parameter int DUMMY_BYTES = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // block_addr[31:0], rx_byte[39:32]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // tx_byte[7:0], data_byte[15:8], status[19:16],
                                   // card_kind[21:20], zero fill
    output logic [2:0]  m_tuser,   // tx_valid, cs_active, data_valid
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] pwr_reg, cto_reg, ito_reg, dto_reg;
    logic        in_v_reg, out_v_reg;
    sdspi_pkg::item_t   in_reg;
    sdspi_pkg::result_t res, out_reg;
    logic        step_en;

    assign cfg_ready = 1'b1;
    assign step_en   = in_v_reg && (!out_v_reg || m_tready);
    assign s_tready  = !in_v_reg || step_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pwr_reg <= 16'd500;
            cto_reg <= 16'd1000;
            ito_reg <= 16'd10000;
            dto_reg <= 16'd1000;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                sdspi_pkg::REG_PWRUP:  pwr_reg <= cfg_data;
                sdspi_pkg::REG_CMDTO:  cto_reg <= cfg_data;
                sdspi_pkg::REG_INITTO: ito_reg <= cfg_data;
                sdspi_pkg::REG_DATATO: dto_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (s_tready) in_v_reg <= s_tvalid;
            if (step_en) out_v_reg <= 1'b1;
            else if (m_tready) out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_reg.cmd        <= s_tuser;
            in_reg.block_addr <= s_tdata[31:0];
            in_reg.rx_byte    <= s_tdata[39:32];
        end
        if (step_en) out_reg <= res;
    end

    sdspi_core #(
        .BLOCK_BYTES(BLOCK_BYTES),
        .DUMMY_BYTES(DUMMY_BYTES)
    ) u_core (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .step_en            (step_en),
        .item               (in_reg),
        .powerup_wait_ticks (pwr_reg),
        .cmd_timeout_ticks  (cto_reg),
        .init_timeout_ticks (ito_reg),
        .data_timeout_ticks (dto_reg),
        .result             (res)
    );

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {2'b00, out_reg.card_kind, out_reg.status, out_reg.data_byte,
                       out_reg.tx_byte};
    assign m_tuser  = {out_reg.data_valid, out_reg.cs_active, out_reg.tx_valid};
    assign m_tlast  = out_reg.data_last;

endmodule

@@ hw/rtl/sdspi_checker.sv @@
// ----------------------------------------------------------------------------
// SD SPI sequencer port checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdspi_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[2])
        else $error("last flag without data");

    a_nodata: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[2] |-> m_tdata[15:8] == 8'd0)
        else $error("data byte without data flag");

    a_txidle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'hFF && !m_tuser[1])
        else $error("idle bus drives a byte");

endmodule

bind sd_spi_init_and_block_read sdspi_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
